### design/bc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the binomial coefficient block.
// Holds the microprogram ROM, its control word layout and operand widths.
// No dependencies.
package bc_pkg;

    localparam int N_W       = 31;
    localparam int MUL_CHUNK = 32;
    localparam int ACC_EXT_W = 2 * MUL_CHUNK;
    localparam int MUL_P_W   = MUL_CHUNK + N_W;
    localparam int PROD_W    = ACC_EXT_W + N_W;

    typedef logic [N_W-1:0] operand_t;
    typedef logic [3:0]     step_t;
    typedef logic [3:0]     op_t;
    typedef logic [3:0]     cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    // Step addresses
    localparam step_t S_WAIT    = 4'd0;
    localparam step_t S_RANGE   = 4'd1;
    localparam step_t S_TRIV    = 4'd2;
    localparam step_t S_LOOP    = 4'd3;
    localparam step_t S_MULHI   = 4'd4;
    localparam step_t S_DIVINIT = 4'd5;
    localparam step_t S_DIV     = 4'd6;
    localparam step_t S_ADV     = 4'd7;
    localparam step_t S_ZERO    = 4'd8;
    localparam step_t S_OVF     = 4'd9;
    localparam step_t S_EMIT    = 4'd10;
    localparam step_t S_RET     = 4'd11;

    // Datapath operations
    localparam op_t O_NOP      = 4'd0;
    localparam op_t O_LOAD     = 4'd1;
    localparam op_t O_REDUCE   = 4'd2;
    localparam op_t O_MUL_LO   = 4'd3;
    localparam op_t O_MUL_HI   = 4'd4;
    localparam op_t O_DIV_INIT = 4'd5;
    localparam op_t O_DIV_STEP = 4'd6;
    localparam op_t O_ADVANCE  = 4'd7;
    localparam op_t O_CLEAR    = 4'd8;
    localparam op_t O_SET_OVF  = 4'd9;
    localparam op_t O_EMIT     = 4'd10;

    // Jump conditions
    localparam cond_t C_NEVER    = 4'd0;
    localparam cond_t C_ALWAYS   = 4'd1;
    localparam cond_t C_IDLE     = 4'd2;
    localparam cond_t C_R_GT_N   = 4'd3;
    localparam cond_t C_TRIVIAL  = 4'd4;
    localparam cond_t C_I_EQ_R   = 4'd5;
    localparam cond_t C_PROD_OVF = 4'd6;
    localparam cond_t C_CNT_NZ   = 4'd7;
    localparam cond_t C_OUT_BUSY = 4'd8;

    function automatic ctrl_word_t ucode_rom(input step_t addr);
        ctrl_word_t w;
        unique case (addr)
            S_WAIT:    w = '{O_LOAD,     C_IDLE,     S_WAIT};
            S_RANGE:   w = '{O_NOP,      C_R_GT_N,   S_ZERO};
            S_TRIV:    w = '{O_REDUCE,   C_TRIVIAL,  S_EMIT};
            S_LOOP:    w = '{O_MUL_LO,   C_I_EQ_R,   S_EMIT};
            S_MULHI:   w = '{O_MUL_HI,   C_NEVER,    S_WAIT};
            S_DIVINIT: w = '{O_DIV_INIT, C_PROD_OVF, S_OVF};
            S_DIV:     w = '{O_DIV_STEP, C_CNT_NZ,   S_DIV};
            S_ADV:     w = '{O_ADVANCE,  C_ALWAYS,   S_LOOP};
            S_ZERO:    w = '{O_CLEAR,    C_ALWAYS,   S_EMIT};
            S_OVF:     w = '{O_SET_OVF,  C_ALWAYS,   S_EMIT};
            S_EMIT:    w = '{O_EMIT,     C_OUT_BUSY, S_EMIT};
            S_RET:     w = '{O_NOP,      C_ALWAYS,   S_WAIT};
            default:   w = '{O_NOP,      C_ALWAYS,   S_WAIT};
        endcase
        return w;
    endfunction

endpackage

### design/bc_in_if.sv
`timescale 1ns / 1ps
// Operand channel of the binomial coefficient block: valid/ready plus n and r.
// Depends on bc_pkg.
interface bc_in_if;
    import bc_pkg::*;

    logic     valid;
    logic     ready;
    operand_t n_total;
    operand_t r_chosen;

    modport source (output valid, output n_total, output r_chosen, input ready);
    modport sink   (input valid, input n_total, input r_chosen, output ready);
endinterface

### design/bc_out_if.sv
`timescale 1ns / 1ps
// Result channel of the binomial coefficient block: valid/ready, count and flag.
// No dependencies.
interface bc_out_if #(
    parameter int RESULT_WIDTH = 64
);
    logic                    valid;
    logic                    ready;
    logic [RESULT_WIDTH-1:0] count_value;
    logic                    overflow_flag;

    modport source (output valid, output count_value, output overflow_flag, input ready);
    modport sink   (input valid, input count_value, input overflow_flag, output ready);
endinterface

### design/binomial_coefficient.sv
`timescale 1ns / 1ps
// Top level of the binomial coefficient block: microprogram sequencer and datapath.
// Depends on bc_pkg, bc_in_if and bc_out_if.
//
// Computes C(n, r) for one operand beat at a time with a 12-step microprogram.
// After r is reduced to r' = min(r, n - r), each round multiplies the running
// count by n - i on one 32x31 multiplier in two passes, checks for overflow,
// then divides exactly by i + 1 in a restoring divider that retires one
// quotient bit per cycle. Each round runs the low and high multiply steps,
// the divider init step, the divide steps and the advance step. The result
// register loads at the emit step after r' rounds, with r' bounded in
// practice by overflow, and the next operand beat is accepted after the
// return step. A round that overflows leaves at the divider init step and
// reaches the emit step through the overflow step. Cases with r > n, r = 0
// or r = n skip the rounds and reach the emit step through the zero step or
// directly. The sequencer holds at its emit step for every cycle that an
// earlier result still waits in the result register. The result register
// lets the next operand beat be accepted while a finished result still
// waits to be taken.
module binomial_coefficient #(
    parameter int RESULT_WIDTH = 64
) (
    input  logic     clk,
    input  logic     rst_n,
    bc_in_if.sink    operands,
    bc_out_if.source result
);
    import bc_pkg::*;

    localparam int CNT_W = $clog2(RESULT_WIDTH);

    step_t                   upc_reg, upc_next;
    operand_t                n_reg, r_reg, i_reg, factor_reg, div_reg;
    logic [RESULT_WIDTH-1:0] acc_reg, q_reg;
    logic                    ovf_reg;
    logic [MUL_P_W-1:0]      plo_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [N_W-1:0]          rem_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    out_valid_reg, out_valid_next;
    logic [RESULT_WIDTH-1:0] out_count_reg;
    logic                    out_ovf_reg;

    ctrl_word_t              cw;
    logic                    take;
    logic                    out_busy;
    logic                    emit_fire;
    logic [ACC_EXT_W-1:0]    acc_ext;
    logic [MUL_CHUNK-1:0]    mul_a;
    logic [MUL_P_W-1:0]      mul_p;
    operand_t                n_minus_r;
    logic [N_W:0]            rem_shift;
    logic [N_W:0]            rem_diff;

    assign cw        = ucode_rom(upc_reg);
    assign out_busy  = out_valid_reg && !result.ready;
    assign take      = (upc_reg == S_WAIT) && operands.valid;
    assign emit_fire = (cw.op == O_EMIT) && !out_busy;

    assign operands.ready = (upc_reg == S_WAIT);

    assign acc_ext   = ACC_EXT_W'(acc_reg);
    assign mul_a     = (cw.op == O_MUL_HI) ? acc_ext[ACC_EXT_W-1:MUL_CHUNK]
                                            : acc_ext[MUL_CHUNK-1:0];
    assign mul_p     = MUL_P_W'(mul_a) * MUL_P_W'(factor_reg);
    assign n_minus_r = n_reg - r_reg;
    assign rem_shift = {rem_reg, q_reg[RESULT_WIDTH-1]};
    assign rem_diff  = rem_shift - {1'b0, div_reg};

    // Sequencer: jump on condition, else advance
    always_comb
    begin
        logic jump;
        case (cw.cond)
            C_NEVER:    jump = 1'b0;
            C_ALWAYS:   jump = 1'b1;
            C_IDLE:     jump = !operands.valid;
            C_R_GT_N:   jump = r_reg > n_reg;
            C_TRIVIAL:  jump = (r_reg == '0) || (r_reg == n_reg);
            C_I_EQ_R:   jump = i_reg == r_reg;
            C_PROD_OVF: jump = |prod_reg[PROD_W-1:RESULT_WIDTH];
            C_CNT_NZ:   jump = cnt_reg != '0;
            C_OUT_BUSY: jump = out_busy;
            default:    jump = 1'b1;
        endcase
        upc_next = jump ? cw.target : step_t'(upc_reg + 4'd1);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= S_WAIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg       <= upc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (cw.op)
            O_LOAD:
            begin
                if (take)
                begin
                    n_reg      <= operands.n_total;
                    r_reg      <= operands.r_chosen;
                    factor_reg <= operands.n_total;
                    i_reg      <= '0;
                    acc_reg    <= RESULT_WIDTH'(1);
                    ovf_reg    <= 1'b0;
                end
            end
            O_REDUCE:
            begin
                if (r_reg > n_minus_r)
                begin
                    r_reg <= n_minus_r;
                end
            end
            O_MUL_LO:
            begin
                plo_reg <= mul_p;
            end
            O_MUL_HI:
            begin
                prod_reg <= {mul_p, {MUL_CHUNK{1'b0}}} + PROD_W'(plo_reg);
            end
            O_DIV_INIT:
            begin
                q_reg   <= prod_reg[RESULT_WIDTH-1:0];
                rem_reg <= '0;
                div_reg <= i_reg + operand_t'(1);
                cnt_reg <= CNT_W'(RESULT_WIDTH - 1);
            end
            O_DIV_STEP:
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (!rem_diff[N_W])
                begin
                    rem_reg <= rem_diff[N_W-1:0];
                    q_reg   <= {q_reg[RESULT_WIDTH-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_shift[N_W-1:0];
                    q_reg   <= {q_reg[RESULT_WIDTH-2:0], 1'b0};
                end
            end
            O_ADVANCE:
            begin
                acc_reg    <= q_reg;
                i_reg      <= i_reg + operand_t'(1);
                factor_reg <= factor_reg - operand_t'(1);
            end
            O_CLEAR:
            begin
                acc_reg <= '0;
            end
            O_SET_OVF:
            begin
                acc_reg <= '0;
                ovf_reg <= 1'b1;
            end
            O_EMIT:
            begin
                if (emit_fire)
                begin
                    out_count_reg <= acc_reg;
                    out_ovf_reg   <= ovf_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign result.valid         = out_valid_reg;
    assign result.count_value   = out_count_reg;
    assign result.overflow_flag = out_ovf_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (operands.valid && operands.ready) |=> (upc_reg == S_RANGE))
        else $error("accepted beat did not start the microprogram");

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |=> (result.valid && result.count_value == $past(acc_reg)))
        else $error("emitted result not presented");

    a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.overflow_flag) |-> (result.count_value == '0))
        else $error("overflow result carries a nonzero count");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == S_DIV) |-> (div_reg != '0))
        else $error("division by zero in divider");

    a_no_busy_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == S_EMIT && out_busy) |=> (upc_reg == S_EMIT && !operands.ready))
        else $error("sequencer left emit step while result register busy");

endmodule
